FILE: design/dfs_pkg.sv
// Shared types and constants for the distance fog shader.
package dfs_pkg;

  localparam int COLOR_W   = 8;
  localparam int DEPTH_W   = 24;
  localparam int FOG_W     = 20;
  localparam int NUM_LANES = 3;

  // Lane order in the packed color vectors.
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  // Pipeline layout: input, multiply, divisor, one stage per quotient bit, output.
  localparam int DIV_STEPS = COLOR_W;
  localparam int DIV_FIRST = 3;
  localparam int LANE_STG  = DIV_FIRST + DIV_STEPS;
  localparam int OUT_STG   = LANE_STG;
  localparam int NUM_STG   = LANE_STG + 1;

  // 255 * depth^2 fits in two depths plus one color width.
  localparam int QW = 2 * DEPTH_W + COLOR_W;

  localparam logic [FOG_W-1:0] FOG_RESET = FOG_W'(50000);

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [FOG_W-1:0]   fog_t;
  typedef logic [QW-1:0]      qval_t;

endpackage

FILE: design/dfs_in_if.sv
// Pixel input channel: color bytes and fixed-point depth.
interface dfs_in_if import dfs_pkg::*; ();
  logic   valid;
  logic   ready;
  color_t red_in;
  color_t green_in;
  color_t blue_in;
  depth_t depth_in;

  modport source(output valid, red_in, green_in, blue_in, depth_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, depth_in, output ready);
endinterface

FILE: design/dfs_out_if.sv
// Pixel output channel: fogged color bytes.
interface dfs_out_if import dfs_pkg::*; ();
  logic   valid;
  logic   ready;
  color_t red_out;
  color_t green_out;
  color_t blue_out;

  modport source(output valid, red_out, green_out, blue_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

FILE: design/distance_fog_shader.sv
// Distance fog shader: scales each color by min(255, fog_numerator/depth^2)/255, exactly,
// using integer math. Takes one pixel per clock and sustains one per clock. The pipeline
// length is set by the divider: each of the three color lanes resolves one quotient bit
// per pipeline stage (8 stages), after input, multiply and divisor stages, and before the
// output register. The pipeline collapses bubbles, so input stalls only when every stage
// is full and the output is held. fog_numerator may be changed only while no pixels are
// in flight.
module distance_fog_shader import dfs_pkg::*; #(
  parameter int DEPTH_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  fog_t        cfg_wr_data,
  dfs_in_if.sink      pix_in,
  dfs_out_if.source   pix_out
);

  logic [NUM_STG-1:0]                   vld;
  logic [NUM_STG-1:0]                   rdy;
  fog_t                                 fog;
  logic [DIV_STEPS-1:0][QW-1:0]         q_taps;
  logic                                 bypass;
  logic [NUM_LANES-1:0][COLOR_W-1:0]    chan_in;
  logic [NUM_LANES-1:0][COLOR_W-1:0]    quot;
  logic [NUM_LANES-1:0][COLOR_W-1:0]    chan;
  logic [NUM_LANES-1:0][COLOR_W-1:0]    pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      fog <= FOG_RESET;
    end else if (cfg_wr_en) begin
      fog <= cfg_wr_data;
    end
  end

  // a stage can load when empty or when its contents move on
  always_comb begin
    rdy[NUM_STG-1] = !vld[NUM_STG-1] || pix_out.ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= pix_in.valid;
      for (int k = 1; k < NUM_STG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign pix_in.ready  = rdy[0];
  assign pix_out.valid = vld[NUM_STG-1];

  assign chan_in[LANE_RED]   = pix_in.red_in;
  assign chan_in[LANE_GREEN] = pix_in.green_in;
  assign chan_in[LANE_BLUE]  = pix_in.blue_in;

  dfs_divisor #(.FRAC_BITS(DEPTH_FRAC_BITS)) u_divisor (
    .clk      (clk),
    .en       (rdy[LANE_STG-1:0]),
    .depth_in (pix_in.depth_in),
    .fog      (fog),
    .q_taps   (q_taps),
    .bypass   (bypass)
  );

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    dfs_lane #(.FRAC_BITS(DEPTH_FRAC_BITS)) u_lane (
      .clk      (clk),
      .en       (rdy[LANE_STG-1:0]),
      .chan_in  (chan_in[l]),
      .fog      (fog),
      .q_taps   (q_taps),
      .quot_out (quot[l]),
      .chan_out (chan[l])
    );
  end

  dfs_merge u_merge (
    .clk    (clk),
    .en     (rdy[OUT_STG]),
    .bypass (bypass),
    .quot   (quot),
    .chan   (chan),
    .pix    (pix)
  );

  assign pix_out.red_out   = pix[LANE_RED];
  assign pix_out.green_out = pix[LANE_GREEN];
  assign pix_out.blue_out  = pix[LANE_BLUE];

endmodule

FILE: design/dfs_divisor.sv
// Shared divisor path: 255*depth^2, clamp decision, and divisor taps for the lanes.
module dfs_divisor import dfs_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic [LANE_STG-1:0]            en,
  input  depth_t                         depth_in,
  input  fog_t                           fog,
  output logic [DIV_STEPS-1:0][QW-1:0]   q_taps,
  output logic                           bypass
);

  localparam int SW = FOG_W + 2 * FRAC_BITS;
  localparam int MW = (QW > SW) ? QW : SW;

  depth_t                   d0;
  logic [2*DEPTH_W-1:0]     dsq;
  qval_t                    qreg [DIV_STEPS];
  logic [DIV_STEPS-1:0]     byp;
  logic [SW-1:0]            scaled_fog;

  assign scaled_fog = SW'(fog) << (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en[0]) d0 <= depth_in;
    if (en[1]) dsq <= (2 * DEPTH_W)'(d0) * (2 * DEPTH_W)'(d0);
    // 255*x computed as (x << 8) - x
    if (en[2]) qreg[0] <= (QW'(dsq) << COLOR_W) - QW'(dsq);
    for (int j = 1; j < DIV_STEPS; j++) begin
      if (en[2 + j]) qreg[j] <= qreg[j-1];
    end
    // brightness >= 255 (or depth zero): pass channels through
    if (en[DIV_FIRST]) byp[0] <= !(MW'(qreg[0]) > MW'(scaled_fog));
    for (int j = 1; j < DIV_STEPS; j++) begin
      if (en[DIV_FIRST + j]) byp[j] <= byp[j-1];
    end
  end

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      q_taps[j] = qreg[j];
    end
  end

  assign bypass = byp[DIV_STEPS-1];

endmodule

FILE: design/dfs_lane.sv
// One color lane: channel times numerator, then a restoring divide, one bit per stage.
module dfs_lane import dfs_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic [LANE_STG-1:0]            en,
  input  color_t                         chan_in,
  input  fog_t                           fog,
  input  logic [DIV_STEPS-1:0][QW-1:0]   q_taps,
  output color_t                         quot_out,
  output color_t                         chan_out
);

  localparam int PW   = COLOR_W + FOG_W;
  localparam int REMW = PW + 2 * FRAC_BITS;
  localparam int CW   = QW + COLOR_W;

  color_t           ch   [LANE_STG];
  logic [PW-1:0]    prod;
  logic [REMW-1:0]  rem  [DIV_STEPS+1];
  color_t           quot [1:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en[0]) ch[0] <= chan_in;
    for (int k = 1; k < LANE_STG; k++) begin
      if (en[k]) ch[k] <= ch[k-1];
    end
    if (en[1]) prod <= PW'(ch[0]) * PW'(fog);
    if (en[2]) rem[0] <= REMW'(prod) << (2 * FRAC_BITS);
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [CW:0] trial;
    logic        qbit;
    color_t      quot_next;

    // trial subtract of divisor aligned to quotient bit (DIV_STEPS-1-j)
    assign trial = {1'b0, CW'(rem[j])} - {1'b0, (CW'(q_taps[j]) << (DIV_STEPS - 1 - j))};
    assign qbit  = !trial[CW];

    if (j == 0) begin : g_first
      assign quot_next = {{(COLOR_W-1){1'b0}}, qbit};
    end else begin : g_rest
      assign quot_next = {quot[j][COLOR_W-2:0], qbit};
    end

    always_ff @(posedge clk) begin
      if (en[DIV_FIRST + j]) begin
        rem[j+1]  <= qbit ? trial[REMW-1:0] : rem[j];
        quot[j+1] <= quot_next;
      end
    end
  end

  assign quot_out = quot[DIV_STEPS];
  assign chan_out = ch[LANE_STG-1];

endmodule

FILE: design/dfs_merge.sv
// Output register: picks quotient or pass-through for every lane.
module dfs_merge import dfs_pkg::*; (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic                                 bypass,
  input  logic [NUM_LANES-1:0][COLOR_W-1:0]    quot,
  input  logic [NUM_LANES-1:0][COLOR_W-1:0]    chan,
  output logic [NUM_LANES-1:0][COLOR_W-1:0]    pix
);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        pix[l] <= bypass ? chan[l] : quot[l];
      end
    end
  end

endmodule

FILE: design/dfs_checker.sv
// Port-level checks for the distance fog shader, bound to the top level.
module dfs_checker import dfs_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input color_t out_red,
  input color_t out_green,
  input color_t out_blue
);

  // held output transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("output payload changed while stalled");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // input backpressure only arises from a stalled output
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind distance_fog_shader dfs_checker u_dfs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_red   (pix_out.red_out),
  .out_green (pix_out.green_out),
  .out_blue  (pix_out.blue_out)
);
